FILE: rtl/flash_slot_wear_leveler_defines.svh
// Assertion helpers used by the checker file.
`ifndef FLASH_SLOT_WEAR_LEVELER_DEFINES_SVH
`define FLASH_SLOT_WEAR_LEVELER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define FSW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fsw check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define FSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fsw check failed");

`endif

FILE: rtl/fsw_pkg.sv
package fsw_pkg;

    localparam logic [2:0] OP_READ      = 3'd0;
    localparam logic [2:0] OP_PROG_BUF  = 3'd1;
    localparam logic [2:0] OP_PROG_BYTE = 3'd2;
    localparam logic [2:0] OP_ERASE     = 3'd3;
    localparam logic [2:0] OP_NONE      = 3'd4;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;

    localparam logic [2:0] REG_MARKER_MODE    = 3'd0;
    localparam logic [2:0] REG_BASE_ADDRESS   = 3'd1;
    localparam logic [2:0] REG_RECORD_BYTES   = 3'd2;
    localparam logic [2:0] REG_SLOT_COUNT     = 3'd3;
    localparam logic [2:0] REG_PAYLOAD_OFFSET = 3'd4;
    localparam logic [2:0] REG_MIDPOINT_SLOT  = 3'd5;

    localparam logic [7:0] VALID_MARK = 8'hA5;
    localparam logic [7:0] CLEAR_MARK = 8'h00;

    typedef struct packed {
        logic [2:0]  op;
        logic [23:0] addr;
        logic [7:0]  val;
    } fixed_item_t;

endpackage

FILE: rtl/flash_slot_wear_leveler.sv
// Flash slot wear-leveler. Keeps a mirror of per-slot metadata (bitmap bits or marker
// valid flags) in two one-bit-wide synchronous memories and turns each read or write
// request into up to five flash command words, the final one flagged by m_last. A
// request scans the mirror one slot per cycle through the memory read port, forms
// addresses in S_MUL and S_SETUP, then emits one word per cycle as the output register
// drains, then updates the mirror, sweeping the slots in use (marker erase) or all
// SLOT_DEPTH slots (bitmap erase). Load and unused commands are taken in S_IDLE.
// After reset a pass over all slots sets every bitmap bit and clears every marker
// flag before s_ready rises; configuration writes are taken at any time. PAGE_BYTES
// and SECTOR_BYTES must be powers of two; the block does not check this.
module flash_slot_wear_leveler
    import fsw_pkg::*;
#(
    parameter int SLOT_DEPTH   = 256,
    parameter int PAGE_BYTES   = 256,
    parameter int SECTOR_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_slot_index,
    input  logic        s_bit_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_flash_op,
    output logic [23:0] m_flash_address,
    output logic [8:0]  m_byte_count,
    output logic [7:0]  m_byte_value,
    output logic [7:0]  m_buffer_offset,
    output logic        m_last
);

    localparam int IW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int NW = $clog2(SLOT_DEPTH + 1);
    localparam int PW = $clog2(PAGE_BYTES);
    localparam int SW = $clog2(SECTOR_BYTES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_SETUP = 4'd3;
    localparam logic [3:0] S_EMIT  = 4'd4;
    localparam logic [3:0] S_UPD   = 4'd5;
    localparam logic [3:0] S_UPD2  = 4'd6;
    localparam logic [3:0] S_SWEEP = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    localparam logic [2:0] U_NONE  = 3'd0;
    localparam logic [2:0] U_BFILL = 3'd1;
    localparam logic [2:0] U_BCLR  = 3'd2;
    localparam logic [2:0] U_MWRAP = 3'd3;
    localparam logic [2:0] U_MNORM = 3'd4;

    localparam logic [1:0] SWK_INIT  = 2'd0;
    localparam logic [1:0] SWK_FILL  = 2'd1;
    localparam logic [1:0] SWK_ERASE = 2'd2;

    logic        marker_mode_reg;
    logic [23:0] base_address_reg;
    logic [7:0]  record_bytes_reg;
    logic [8:0]  slot_count_reg;
    logic [11:0] payload_offset_reg;
    logic [7:0]  midpoint_slot_reg;

    logic bits_mem  [SLOT_DEPTH];
    logic marks_mem [SLOT_DEPTH];
    logic bits_rd_reg, marks_rd_reg;
    logic bits_we, bits_wd, marks_we, marks_wd;
    logic [IW-1:0] bits_wa, marks_wa, rd_addr;

    logic [3:0]    state_reg;
    logic          wr_reg;
    logic [IW-1:0] scan_i_reg, rd_idx_reg, idx_reg;
    logic          rd_pend_reg, found_reg;
    logic [23:0]   prod_reg;

    fixed_item_t   pre_reg [3];
    logic [1:0]    pre_n_reg, pre_pos_reg;
    logic          post_en_reg;
    fixed_item_t   post_reg;
    logic [7:0]    pay_len_reg, pay_boff_reg;
    logic [23:0]   pay_addr_reg;
    logic [2:0]    pay_bud_reg;
    logic [2:0]    upd_reg;
    logic          mid_reg;

    logic [1:0]    swk_reg;
    logic          sw_both_reg, fin_zero_reg;
    logic [IW-1:0] sw_i_reg;
    logic [23:0]   sw_a_reg;

    logic          m_valid_reg, m_last_reg;
    logic [2:0]    m_op_reg;
    logic [23:0]   m_addr_reg;
    logic [8:0]    m_cnt_reg;
    logic [7:0]    m_val_reg, m_boff_reg;

    logic [NW-1:0] n_eff;
    logic [IW-1:0] n_m1;
    logic [8:0]    stride;
    logic [23:0]   data0, sec2;
    logic          scan_bit, out_free, load_ok;
    logic [PW:0]   room;
    logic [7:0]    chunk;
    logic [NW-1:0] mul_a;
    logic          sw_hit;
    logic [IW-1:0] sw_end;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    always_comb begin
        if (32'(slot_count_reg) > SLOT_DEPTH) begin
            n_eff = NW'(SLOT_DEPTH);
        end else if (slot_count_reg == 9'd0) begin
            n_eff = NW'(1);
        end else begin
            n_eff = NW'(slot_count_reg);
        end
    end

    assign n_m1     = IW'(n_eff - NW'(1));
    assign stride   = {1'b0, record_bytes_reg} + 9'd1;
    assign data0    = base_address_reg + {12'd0, payload_offset_reg};
    assign sec2     = base_address_reg + 24'(SECTOR_BYTES);
    assign scan_bit = marker_mode_reg ? marks_rd_reg : bits_rd_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign load_ok  = (32'(s_slot_index) < SLOT_DEPTH);
    assign rd_addr  = scan_i_reg;
    assign room     = (PW + 1)'(PAGE_BYTES) - {1'b0, pay_addr_reg[PW-1:0]};
    assign chunk    = (pay_bud_reg == 3'd1 || 32'(pay_len_reg) <= 32'(room))
                      ? pay_len_reg : 8'(room);
    assign sw_hit   = (sw_a_reg[23:SW] == base_address_reg[23:SW])
                      || (sw_both_reg && sw_a_reg[23:SW] == sec2[23:SW]);
    assign sw_end   = (swk_reg == SWK_ERASE) ? n_m1 : IW'(SLOT_DEPTH - 1);

    always_comb begin
        if (!marker_mode_reg && wr_reg) begin
            mul_a = NW'(idx_reg) + NW'(1);
        end else if (found_reg) begin
            mul_a = NW'(idx_reg);
        end else begin
            mul_a = NW'(n_m1);
        end
    end

    always_comb begin
        bits_we  = 1'b0;
        bits_wd  = 1'b0;
        bits_wa  = sw_i_reg;
        marks_we = 1'b0;
        marks_wd = 1'b0;
        marks_wa = sw_i_reg;
        unique case (state_reg)
            S_IDLE: begin
                bits_wa  = IW'(s_slot_index);
                marks_wa = IW'(s_slot_index);
                bits_wd  = s_bit_value;
                marks_wd = s_bit_value;
                if (s_valid && s_cmd == CMD_LOAD && load_ok) begin
                    bits_we  = !marker_mode_reg;
                    marks_we = marker_mode_reg;
                end
            end
            S_UPD: begin
                bits_wa  = idx_reg;
                marks_wa = idx_reg;
                bits_we  = (upd_reg == U_BCLR);
                marks_we = (upd_reg == U_MNORM);
            end
            S_UPD2: begin
                marks_wa = IW'(NW'(idx_reg) + NW'(1));
                marks_wd = 1'b1;
                marks_we = 1'b1;
            end
            S_SWEEP: begin
                unique case (swk_reg)
                    SWK_INIT: begin
                        bits_we  = 1'b1;
                        bits_wd  = 1'b1;
                        marks_we = 1'b1;
                    end
                    SWK_FILL: begin
                        bits_we = 1'b1;
                        bits_wd = 1'b1;
                    end
                    default: begin
                        marks_we = sw_hit;
                    end
                endcase
            end
            S_FIN: begin
                marks_wa = '0;
                marks_wd = 1'b1;
                marks_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (bits_we) begin
            bits_mem[bits_wa] <= bits_wd;
        end
        if (marks_we) begin
            marks_mem[marks_wa] <= marks_wd;
        end
        bits_rd_reg  <= bits_mem[rd_addr];
        marks_rd_reg <= marks_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_mode_reg    <= 1'b0;
            base_address_reg   <= 24'd65536;
            record_bytes_reg   <= 8'd96;
            slot_count_reg     <= 9'd32;
            payload_offset_reg <= 12'd16;
            midpoint_slot_reg  <= 8'd41;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MARKER_MODE:    marker_mode_reg    <= cfg_data[0];
                REG_BASE_ADDRESS:   base_address_reg   <= cfg_data;
                REG_RECORD_BYTES:   record_bytes_reg   <= cfg_data[7:0];
                REG_SLOT_COUNT:     slot_count_reg     <= cfg_data[8:0];
                REG_PAYLOAD_OFFSET: payload_offset_reg <= cfg_data[11:0];
                REG_MIDPOINT_SLOT:  midpoint_slot_reg  <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_SWEEP;
            swk_reg      <= SWK_INIT;
            sw_i_reg     <= '0;
            fin_zero_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && (s_cmd == CMD_READ || s_cmd == CMD_WRITE)) begin
                        wr_reg      <= (s_cmd == CMD_WRITE);
                        scan_i_reg  <= '0;
                        rd_pend_reg <= 1'b0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    rd_pend_reg <= 1'b1;
                    rd_idx_reg  <= scan_i_reg;
                    if (scan_i_reg != n_m1) begin
                        scan_i_reg <= scan_i_reg + IW'(1);
                    end
                    if (rd_pend_reg && scan_bit) begin
                        found_reg <= 1'b1;
                        idx_reg   <= rd_idx_reg;
                        state_reg <= S_MUL;
                    end else if (rd_pend_reg && rd_idx_reg == n_m1) begin
                        found_reg <= 1'b0;
                        idx_reg   <= rd_idx_reg;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= 24'(mul_a) * 24'(marker_mode_reg ? stride
                                                  : {1'b0, record_bytes_reg});
                    state_reg <= S_SETUP;
                end
                S_SETUP: begin
                    pre_pos_reg  <= 2'd0;
                    pay_boff_reg <= 8'd0;
                    state_reg    <= S_EMIT;
                    if (!marker_mode_reg) begin
                        mid_reg <= 1'b0;
                        if (!wr_reg) begin
                            pre_reg[0]  <= '{OP_READ, data0 + prod_reg, 8'd0};
                            pre_n_reg   <= 2'd1;
                            post_en_reg <= 1'b0;
                            pay_len_reg <= 8'd0;
                            upd_reg     <= U_NONE;
                        end else if (!found_reg || idx_reg == n_m1) begin
                            pre_reg[0]   <= '{OP_ERASE, base_address_reg, 8'd0};
                            pre_n_reg    <= 2'd1;
                            post_en_reg  <= 1'b0;
                            pay_len_reg  <= record_bytes_reg;
                            pay_addr_reg <= data0;
                            pay_bud_reg  <= 3'd4;
                            upd_reg      <= U_BFILL;
                        end else begin
                            pre_n_reg    <= 2'd0;
                            pay_len_reg  <= record_bytes_reg;
                            pay_addr_reg <= data0 + prod_reg;
                            pay_bud_reg  <= 3'd4;
                            post_en_reg  <= 1'b1;
                            post_reg     <= '{OP_PROG_BYTE,
                                base_address_reg + 24'(idx_reg >> 3),
                                ~(8'd1 << idx_reg[2:0])};
                            upd_reg      <= U_BCLR;
                        end
                    end else begin
                        if (!wr_reg) begin
                            pre_n_reg   <= 2'd1;
                            post_en_reg <= 1'b0;
                            pay_len_reg <= 8'd0;
                            upd_reg     <= U_NONE;
                            mid_reg     <= 1'b0;
                            if (found_reg) begin
                                pre_reg[0] <= '{OP_READ,
                                    base_address_reg + prod_reg + 24'd1, 8'd0};
                            end else begin
                                pre_reg[0] <= '{OP_NONE, 24'd0, 8'd0};
                            end
                        end else if (!found_reg || idx_reg == n_m1) begin
                            if (!found_reg) begin
                                pre_reg[0] <= '{OP_ERASE, base_address_reg, 8'd0};
                                pre_reg[1] <= '{OP_ERASE, sec2, 8'd0};
                            end else begin
                                pre_reg[0] <= '{OP_ERASE, sec2, 8'd0};
                                pre_reg[1] <= '{OP_ERASE, base_address_reg, 8'd0};
                            end
                            pre_reg[2]   <= '{OP_PROG_BYTE, base_address_reg, VALID_MARK};
                            pre_n_reg    <= 2'd3;
                            post_en_reg  <= 1'b0;
                            pay_len_reg  <= record_bytes_reg;
                            pay_addr_reg <= base_address_reg + 24'd1;
                            pay_bud_reg  <= 3'd2;
                            upd_reg      <= U_MWRAP;
                            mid_reg      <= 1'b0;
                        end else begin
                            pre_reg[0]   <= '{OP_PROG_BYTE, base_address_reg + prod_reg,
                                              CLEAR_MARK};
                            pre_reg[1]   <= '{OP_PROG_BYTE,
                                base_address_reg + prod_reg + 24'(stride), VALID_MARK};
                            pre_n_reg    <= 2'd2;
                            pay_len_reg  <= record_bytes_reg;
                            pay_addr_reg <= base_address_reg + prod_reg + 24'(stride)
                                            + 24'd1;
                            upd_reg      <= U_MNORM;
                            if (32'(idx_reg) == 32'(midpoint_slot_reg)) begin
                                mid_reg     <= 1'b1;
                                pay_bud_reg <= 3'd2;
                                post_en_reg <= 1'b1;
                                post_reg    <= '{OP_ERASE, base_address_reg, 8'd0};
                            end else begin
                                mid_reg     <= 1'b0;
                                pay_bud_reg <= 3'd3;
                                post_en_reg <= 1'b0;
                            end
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        priority if (pre_pos_reg != pre_n_reg) begin
                            m_op_reg   <= pre_reg[pre_pos_reg].op;
                            m_addr_reg <= pre_reg[pre_pos_reg].addr;
                            m_val_reg  <= pre_reg[pre_pos_reg].val;
                            m_boff_reg <= 8'd0;
                            if (pre_reg[pre_pos_reg].op == OP_PROG_BYTE) begin
                                m_cnt_reg <= 9'd1;
                            end else if (pre_reg[pre_pos_reg].op == OP_READ) begin
                                m_cnt_reg <= {1'b0, record_bytes_reg};
                            end else begin
                                m_cnt_reg <= 9'd0;
                            end
                            pre_pos_reg <= pre_pos_reg + 2'd1;
                            m_last_reg  <= (pre_pos_reg + 2'd1 == pre_n_reg)
                                           && pay_len_reg == 8'd0 && !post_en_reg;
                            if ((pre_pos_reg + 2'd1 == pre_n_reg)
                                && pay_len_reg == 8'd0 && !post_en_reg) begin
                                state_reg <= S_UPD;
                            end
                        end else if (pay_len_reg != 8'd0) begin
                            m_op_reg     <= OP_PROG_BUF;
                            m_addr_reg   <= pay_addr_reg;
                            m_cnt_reg    <= {1'b0, chunk};
                            m_val_reg    <= 8'd0;
                            m_boff_reg   <= pay_boff_reg;
                            m_last_reg   <= (chunk == pay_len_reg) && !post_en_reg;
                            pay_addr_reg <= pay_addr_reg + 24'(chunk);
                            pay_boff_reg <= pay_boff_reg + chunk;
                            pay_len_reg  <= pay_len_reg - chunk;
                            pay_bud_reg  <= pay_bud_reg - 3'd1;
                            if ((chunk == pay_len_reg) && !post_en_reg) begin
                                state_reg <= S_UPD;
                            end
                        end else begin
                            m_op_reg   <= post_reg.op;
                            m_addr_reg <= post_reg.addr;
                            m_val_reg  <= post_reg.val;
                            m_boff_reg <= 8'd0;
                            m_cnt_reg  <= (post_reg.op == OP_PROG_BYTE) ? 9'd1 : 9'd0;
                            m_last_reg <= 1'b1;
                            state_reg  <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    sw_i_reg    <= '0;
                    sw_a_reg    <= base_address_reg;
                    sw_both_reg <= (upd_reg == U_MWRAP);
                    unique case (upd_reg)
                        U_BFILL: begin
                            swk_reg      <= SWK_FILL;
                            fin_zero_reg <= 1'b0;
                            state_reg    <= S_SWEEP;
                        end
                        U_MWRAP: begin
                            swk_reg      <= SWK_ERASE;
                            fin_zero_reg <= 1'b1;
                            state_reg    <= S_SWEEP;
                        end
                        U_MNORM: begin
                            state_reg <= S_UPD2;
                        end
                        default: begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_UPD2: begin
                    if (mid_reg) begin
                        swk_reg      <= SWK_ERASE;
                        fin_zero_reg <= 1'b0;
                        state_reg    <= S_SWEEP;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SWEEP: begin
                    sw_i_reg <= sw_i_reg + IW'(1);
                    sw_a_reg <= sw_a_reg + 24'(stride);
                    if (sw_i_reg == sw_end) begin
                        state_reg <= fin_zero_reg ? S_FIN : S_IDLE;
                    end
                end
                S_FIN: begin
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_flash_op      = m_op_reg;
    assign m_flash_address = m_addr_reg;
    assign m_byte_count    = m_cnt_reg;
    assign m_byte_value    = m_val_reg;
    assign m_buffer_offset = m_boff_reg;
    assign m_last          = m_last_reg;

endmodule

FILE: rtl/fsw_checker.sv
`include "flash_slot_wear_leveler_defines.svh"

module fsw_checker
    import fsw_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_flash_op,
    input logic [8:0]  m_byte_count,
    input logic [7:0]  m_byte_value,
    input logic        m_last
);

    `FSW_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_flash_op))
    `FSW_ASSERT_IMPL(a_byte_prog_len, m_valid && m_flash_op == OP_PROG_BYTE, m_byte_count == 9'd1)
    `FSW_ASSERT_IMPL(a_none_is_last, m_valid && m_flash_op == OP_NONE, m_last && m_byte_count == 9'd0)
    `FSW_ASSERT_IMPL(a_erase_clean, m_valid && m_flash_op == OP_ERASE, m_byte_count == 9'd0 && m_byte_value == 8'd0)

endmodule

bind flash_slot_wear_leveler fsw_checker u_fsw_checker (.*);
